/* rtl/cst_pkg.sv */
// Package for the C++ source tokenizer: widths, scan modes, token kinds,
// result and queue record types. No dependencies.
`timescale 1ns / 1ps
package cst_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int LINE_BITS   = 24;
  localparam int KIND_BITS   = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [LINE_BITS-1:0]   line_t;

  // Token kinds as seen on the output
  localparam kind_t KIND_CHAR      = kind_t'(0);
  localparam kind_t KIND_STRING    = kind_t'(1);
  localparam kind_t KIND_COMMENT   = kind_t'(2);
  localparam kind_t KIND_IDENT     = kind_t'(3);
  localparam kind_t KIND_DIRECTIVE = kind_t'(4);
  localparam kind_t KIND_NUMBER    = kind_t'(5);
  localparam kind_t KIND_OP        = kind_t'(6);
  localparam kind_t KIND_WSPACE    = kind_t'(7);
  localparam kind_t KIND_ERROR     = kind_t'(8);

  // Scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_CHAR,
    MODE_STRING,
    MODE_BCOMMENT,
    MODE_LCOMMENT,
    MODE_IDENT,
    MODE_DIRECTIVE,
    MODE_NUMBER,
    MODE_WSPACE,
    MODE_BACKSLASH,
    MODE_PENDING
  } mode_t;

  typedef struct packed {
    kind_t kind;
    len_t  len;
    line_t line;
  } result_t;

  // One queue record: all results caused by one byte (one or two)
  typedef struct packed {
    logic    two;
    logic    fin;
    result_t r0;
    result_t r1;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

  typedef struct packed {
    logic at_reset;
  } front_stat_t;

endpackage

/* rtl/cst_if.sv */
// Channel interfaces for the tokenizer: source bytes in, tokens out.
// Depends on cst_pkg for field widths.
`timescale 1ns / 1ps
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface cst_out_if;
  logic                             valid;
  logic                             ready;
  logic [cst_pkg::KIND_BITS-1:0]    token_kind;
  logic [cst_pkg::LENGTH_BITS-1:0]  token_length;
  logic [cst_pkg::LINE_BITS-1:0]    line_number;
  logic                             final_token;

  modport source (output valid, output token_kind, output token_length,
                  output line_number, output final_token, input ready);
  modport sink (input valid, input token_kind, input token_length,
                input line_number, input final_token, output ready);
endinterface

/* rtl/cst_front.sv */
// Front end: accepts one byte per cycle unless the queue is full, runs the
// scanner state and records the tokens a byte ends. Uses cst_pkg, cst_if.
`timescale 1ns / 1ps
module cst_front (
  input  logic                 clk,
  input  logic                 rst,
  cst_in_if.sink               chars,
  input  logic                 q_full,
  output cst_pkg::q_wr_t       qwr,
  output cst_pkg::front_stat_t stat
);
  import cst_pkg::*;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam len_t  LEN_MAX  = '1;
  localparam line_t LINE_MAX = '1;
  localparam len_t  LEN_ONE  = len_t'(1);
  localparam len_t  LEN_TWO  = len_t'(2);
  localparam line_t LINE_ONE = line_t'(1);

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic may_pair(input logic [7:0] c);
    return c == ">" || c == "<" || c == ":" || c == "=" || c == "!" ||
           c == "-" || c == "&" || c == "|" || c == CH_SLASH;
  endfunction

  function automatic logic single_op(input logic [7:0] c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
           c == "}" || c == "," || c == "." || c == "+" || c == CH_STAR ||
           c == "?" || c == "%" || c == "^" || c == ";";
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] c);
    return (a == ">" && (c == ">" || c == "=")) ||
           (a == "<" && (c == "<" || c == "=")) ||
           (a == ":" && c == ":") || (a == "=" && c == "=") ||
           (a == "!" && c == "=") || (a == "-" && c == ">") ||
           (a == "&" && c == "&") || (a == "|" && c == "|");
  endfunction

  // Scanner state
  mode_t      mode, mode_next;
  len_t       run_len, run_len_next;
  line_t      line_cnt, line_cnt_next;
  logic [7:0] held, held_next;
  logic       esc, esc_next;
  logic       star, star_next;

  logic       [7:0] b;
  logic       last, accept, nl;
  len_t       len_inc;
  line_t      line_inc;

  // Start-of-token decode
  mode_t      st_mode;
  len_t       st_len;
  logic       st_emit;
  kind_t      st_kind;

  logic       do_start;
  logic       ea_v, eb_v, ef_v;
  result_t    ea, eb, ef;

  assign b            = chars.char_in;
  assign last         = chars.end_of_text;
  assign chars.ready  = !q_full;
  assign accept       = chars.valid && chars.ready;
  assign nl           = (b == CH_NL);
  assign len_inc      = (run_len == LEN_MAX) ? run_len : run_len + LEN_ONE;
  assign line_inc     = (nl && line_cnt != LINE_MAX) ? line_cnt + LINE_ONE : line_cnt;
  assign stat.at_reset = (mode == MODE_IDLE) && (line_cnt == LINE_ONE);

  // What a byte does when it opens a token
  always_comb begin
    st_mode = MODE_IDLE;
    st_len  = LEN_ONE;
    st_emit = 1'b0;
    st_kind = KIND_OP;
    priority if (b == CH_SQ) begin
      st_mode = MODE_CHAR;
    end else if (b == CH_DQ) begin
      st_mode = MODE_STRING;
    end else if (is_alpha(b) || b == "_" || b == "~") begin
      st_mode = MODE_IDENT;
    end else if (b == CH_HASH) begin
      st_mode = MODE_DIRECTIVE;
    end else if (is_digit(b)) begin
      st_mode = MODE_NUMBER;
    end else if (may_pair(b)) begin
      st_mode = MODE_PENDING;
    end else if (single_op(b)) begin
      st_len  = '0;
      st_emit = 1'b1;
    end else if (is_space(b)) begin
      st_mode = MODE_WSPACE;
    end else if (b == CH_BS) begin
      st_mode = MODE_BACKSLASH;
      st_len  = '0;
    end else begin
      st_len  = '0;
      st_emit = 1'b1;
      st_kind = KIND_ERROR;
    end
  end

  // Per-mode scan step, then end-of-source flush
  always_comb begin
    mode_next     = mode;
    run_len_next  = run_len;
    held_next     = held;
    esc_next      = esc;
    star_next     = star;
    line_cnt_next = line_inc;
    do_start      = 1'b0;
    ea_v          = 1'b0;
    ea            = '{kind: KIND_OP, len: run_len, line: line_cnt};
    unique case (mode)
      MODE_CHAR, MODE_STRING: begin
        run_len_next = len_inc;
        if (esc) begin
          esc_next = 1'b0;
        end else if (b == CH_BS) begin
          esc_next = 1'b1;
        end else if ((mode == MODE_CHAR && b == CH_SQ) ||
                     (mode == MODE_STRING && b == CH_DQ)) begin
          ea_v         = 1'b1;
          ea.kind      = (mode == MODE_CHAR) ? KIND_CHAR : KIND_STRING;
          ea.len       = len_inc;
          ea.line      = line_inc;
          mode_next    = MODE_IDLE;
          run_len_next = '0;
        end
      end
      MODE_BCOMMENT: begin
        run_len_next = len_inc;
        if (star && b == CH_SLASH) begin
          ea_v         = 1'b1;
          ea.kind      = KIND_COMMENT;
          ea.len       = len_inc;
          ea.line      = line_inc;
          mode_next    = MODE_IDLE;
          run_len_next = '0;
          star_next    = 1'b0;
        end else begin
          star_next = (b == CH_STAR);
        end
      end
      MODE_LCOMMENT: begin
        do_start = nl;
      end
      MODE_IDENT, MODE_DIRECTIVE, MODE_NUMBER, MODE_WSPACE: begin
        logic member;
        member = 1'b0;
        unique case (mode)
          MODE_IDENT: begin
            member  = is_alpha(b) || is_digit(b) || b == "_" || b == "~";
            ea.kind = KIND_IDENT;
          end
          MODE_DIRECTIVE: begin
            member  = is_alpha(b);
            ea.kind = KIND_DIRECTIVE;
          end
          MODE_NUMBER: begin
            member  = is_digit(b) || b == ".";
            ea.kind = KIND_NUMBER;
          end
          default: begin
            member  = is_space(b);
            ea.kind = KIND_WSPACE;
          end
        endcase
        if (member) begin
          run_len_next = len_inc;
        end else begin
          ea_v     = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_BACKSLASH: begin
        do_start = !is_space(b);
      end
      MODE_PENDING: begin
        if (held == CH_SLASH && b == CH_STAR) begin
          mode_next    = MODE_BCOMMENT;
          run_len_next = len_inc;
          star_next    = 1'b0;
        end else if (held == CH_SLASH && b == CH_SLASH) begin
          mode_next    = MODE_LCOMMENT;
          run_len_next = '0;
        end else if (is_pair(held, b)) begin
          ea_v         = 1'b1;
          ea.len       = LEN_TWO;
          mode_next    = MODE_IDLE;
          run_len_next = '0;
        end else begin
          ea_v     = 1'b1;
          ea.len   = LEN_ONE;
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    eb_v = 1'b0;
    eb   = '{kind: st_kind, len: LEN_ONE, line: line_cnt};
    if (do_start) begin
      mode_next    = st_mode;
      run_len_next = st_len;
      held_next    = b;
      esc_next     = 1'b0;
      star_next    = 1'b0;
      eb_v         = st_emit;
    end

    // Open token at the end of the source
    ef_v = last;
    ef   = '{kind: KIND_OP, len: run_len_next, line: line_inc};
    unique case (mode_next)
      MODE_CHAR:      ef.kind = KIND_CHAR;
      MODE_STRING:    ef.kind = KIND_STRING;
      MODE_BCOMMENT:  ef.kind = KIND_COMMENT;
      MODE_IDENT:     ef.kind = KIND_IDENT;
      MODE_DIRECTIVE: ef.kind = KIND_DIRECTIVE;
      MODE_NUMBER:    ef.kind = KIND_NUMBER;
      MODE_WSPACE:    ef.kind = KIND_WSPACE;
      MODE_PENDING:   ef.len  = LEN_ONE;
      default:        ef_v    = 1'b0;
    endcase

    if (last) begin
      mode_next     = MODE_IDLE;
      run_len_next  = '0;
      line_cnt_next = LINE_ONE;
      held_next     = '0;
      esc_next      = 1'b0;
      star_next     = 1'b0;
    end
  end

  // Pack results in order into one queue record
  always_comb begin
    qwr.push     = accept && (ea_v || eb_v || ef_v);
    qwr.rec.fin  = last;
    qwr.rec.two  = (ea_v && (eb_v || ef_v));
    qwr.rec.r0   = ea_v ? ea : (eb_v ? eb : ef);
    qwr.rec.r1   = eb_v ? eb : ef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      run_len  <= '0;
      line_cnt <= LINE_ONE;
      held     <= '0;
      esc      <= 1'b0;
      star     <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      run_len  <= run_len_next;
      line_cnt <= line_cnt_next;
      held     <= held_next;
      esc      <= esc_next;
      star     <= star_next;
    end
  end

endmodule

/* rtl/cst_queue.sv */
// Record queue between scanner and token output, register based.
// Depends on cst_pkg.
`timescale 1ns / 1ps
module cst_queue (
  input  logic          clk,
  input  logic          rst,
  input  cst_pkg::q_wr_t qwr,
  output logic          full,
  input  logic          pop,
  output cst_pkg::rec_t rdata,
  output logic          nonempty
);
  import cst_pkg::*;

  rec_t               entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push, do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = entries[rd_ptr];
  assign do_push  = qwr.push && !full;
  assign do_pop   = pop && nonempty;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= qwr.rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/cst_back.sv */
// Back end: takes records from the queue and presents their tokens from an
// output register, one per cycle unless stalled. Uses cst_pkg, cst_if.
`timescale 1ns / 1ps
module cst_back (
  input  logic          clk,
  input  logic          rst,
  input  cst_pkg::rec_t q_data,
  input  logic          q_valid,
  output logic          pop,
  cst_out_if.source     tokens
);
  import cst_pkg::*;

  rec_t    cur;
  logic    busy;
  logic    sub;
  logic    rec_done;
  logic    take;
  result_t shown;

  assign rec_done = sub || !cur.two;
  assign take     = busy && tokens.ready;
  assign pop      = q_valid && (!busy || (take && rec_done));
  assign shown    = sub ? cur.r1 : cur.r0;

  assign tokens.valid        = busy;
  assign tokens.token_kind   = shown.kind;
  assign tokens.token_length = shown.len;
  assign tokens.line_number  = shown.line;
  assign tokens.final_token  = cur.fin && rec_done;

  // Held record
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // Output valid and position within the record
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sub  <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
      sub  <= 1'b0;
    end else if (take) begin
      if (rec_done) begin
        busy <= 1'b0;
      end else begin
        sub <= 1'b1;
      end
    end
  end

endmodule

/* rtl/cpp_source_tokenizer_top.sv */
// Top level of the C++ source tokenizer: scanner front end, record queue
// and token output stage. Depends on cst_pkg, cst_if and the three submodules.
//
//  channel  | dir | payload                                         | accepted when
//  chars    | in  | char_in[7:0], end_of_text                       | valid && ready
//  tokens   | out | token_kind[3:0], token_length[15:0],            | valid && ready
//           |     | line_number[23:0], final_token                  |
//
// One byte is taken per cycle while the 4-record queue has room; the scanner
// decides each byte combinationally. While tokens.ready is high, results leave
// one per cycle; a byte that completes two tokens holds the output stage until
// both are taken. A token passes through a queue entry and the output stage's
// held record. Reset (rst, synchronous) returns the scanner to idle, line 1,
// and empties the queue. An output stall fills the queue, then drops chars.ready.
`timescale 1ns / 1ps
module cpp_source_tokenizer_top (
  input logic       clk,
  input logic       rst,
  cst_in_if.sink    chars,
  cst_out_if.source tokens
);
  import cst_pkg::*;

  q_wr_t       qwr;
  front_stat_t fstat;
  rec_t        q_data;
  logic        q_full, q_valid, pop;

  cst_front u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .q_full (q_full),
    .qwr    (qwr),
    .stat   (fstat)
  );

  cst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .qwr      (qwr),
    .full     (q_full),
    .pop      (pop),
    .rdata    (q_data),
    .nonempty (q_valid)
  );

  cst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .pop     (pop),
    .tokens  (tokens)
  );

`ifndef NO_ASSERTIONS
  // Scanner never writes a record the queue cannot hold
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qwr.push |-> !q_full)
    else $error("record written into a full queue");

  // Output stage only pulls from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // The final byte of a source leaves the scanner at its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready && chars.end_of_text) |=> fstat.at_reset)
    else $error("scanner not back to idle after end of source");
`endif

endmodule
